@@ design/cpr_pkg.sv @@
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared constants, codes and controller/datapath interface types for the
// channel persistence ranker.
// ----------------------------------------------------------------------------
`default_nettype none

package cpr_pkg;

    // Table and report sizes.
    localparam int unsigned MAX_CHANNELS = 64;
    localparam int unsigned MAX_REPORT   = 8;
    localparam int unsigned ADDR_W       = 6;
    localparam int unsigned CNT_W        = 7;
    localparam int unsigned LANE_W       = $clog2(MAX_REPORT);
    localparam int unsigned FOUND_W      = 4;

    // Item kinds carried in the slave-side tuser.
    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_REPORT = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_SPARE  = 2'd3
    } t_kind;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD     = 2'd1;
    localparam logic [1:0] CFG_PERSIST       = 2'd2;
    localparam logic [1:0] CFG_REPORT_LIMIT  = 2'd3;

    // Configuration reset values.
    localparam logic [6:0]        RST_CHANNEL_COUNT = 7'd64;
    localparam logic signed [7:0] RST_THRESHOLD     = -8'sd70;
    localparam logic [7:0]        RST_PERSIST       = 8'd3;
    localparam logic [3:0]        RST_REPORT_LIMIT  = 4'd8;

    // Table constants.
    localparam logic signed [7:0] LEVEL_RESET = -8'sd120;
    localparam logic signed [7:0] LEVEL_FLOOR = -8'sd128;
    localparam logic [7:0]        STREAK_MAX  = 8'hFF;
    localparam logic [15:0]       PASS_MAX    = 16'hFFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic sample_start;
        logic sample_wr;
        logic clear;
        logic scan_start;
        logic scan_step;
        logic emit_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ch_in_range;
        logic scan_done;
        logic out_free;
        logic emit_last;
    } t_stat;

endpackage

`default_nettype wire

@@ design/cpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// cpr_ctrl
// Controller state machine: decodes item kinds and sequences sample updates,
// report scans and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    input  wire logic [1:0]     i_kind,
    input  wire cpr_pkg::t_stat i_stat,
    output logic                o_s_tready,
    output cpr_pkg::t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SAMPLE = 4'b0010,
        S_SCAN   = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (cpr_pkg::t_kind'(i_kind))
                        cpr_pkg::KIND_SAMPLE: begin
                            if (i_stat.ch_in_range) begin
                                o_cmd.sample_start = 1'b1;
                                n_state            = S_SAMPLE;
                            end
                        end
                        cpr_pkg::KIND_REPORT: begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                        cpr_pkg::KIND_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SAMPLE: begin
                o_cmd.sample_wr = 1'b1;
                n_state         = S_IDLE;
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ design/cpr_dpath.sv @@
// ----------------------------------------------------------------------------
// cpr_dpath
// Datapath: configuration registers, channel table memory with valid flags,
// pass counter, sorted report lanes and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_addr,
    input  wire logic [7:0]                    i_cfg_wdata,
    input  wire logic [cpr_pkg::ADDR_W-1:0]    i_in_ch,
    input  wire logic signed [8:0]             i_in_rssi,
    input  wire cpr_pkg::t_cmd                 i_cmd,
    output cpr_pkg::t_stat                     o_stat,
    input  wire logic                          i_m_tready,
    output logic                               o_m_tvalid,
    output logic [47:0]                        o_m_tdata,
    output logic [0:0]                         o_m_tuser,
    output logic                               o_m_tlast
);

    // Configuration.
    logic [6:0]        r_chan_cnt;
    logic signed [7:0] r_thr;
    logic [7:0]        r_persist;
    logic [3:0]        r_rep_lim;
    logic [cpr_pkg::CNT_W-1:0]   n_act;
    logic [cpr_pkg::FOUND_W-1:0] lim;

    // Table storage: word is {streak, level}.
    logic [15:0]                       r_mem [cpr_pkg::MAX_CHANNELS];
    logic [cpr_pkg::MAX_CHANNELS-1:0]  r_valid;
    logic [15:0]                       r_rd_word;
    logic                              r_rd_init;
    logic [cpr_pkg::ADDR_W-1:0]        rd_addr;

    // Sample update.
    logic [cpr_pkg::ADDR_W-1:0] r_smp_ch;
    logic signed [8:0]          r_smp_rssi;
    logic signed [8:0]          thr_ext;
    logic [7:0]                 old_stk;
    logic [7:0]                 n_stk;
    logic signed [7:0]          n_lvl;
    logic [15:0]                r_pass;

    // Scan.
    logic [cpr_pkg::CNT_W-1:0]   r_idx;
    logic                        r_eval_v;
    logic [cpr_pkg::ADDR_W-1:0]  r_eval_ch;
    logic [cpr_pkg::FOUND_W-1:0] r_found;
    logic [cpr_pkg::LANE_W-1:0]  r_emit;
    logic signed [7:0]           ev_lvl;
    logic [7:0]                  ev_stk;
    logic                        hit;

    // Report lanes, kept sorted by descending level.
    logic [cpr_pkg::ADDR_W-1:0] r_lst_ch  [cpr_pkg::MAX_REPORT];
    logic signed [7:0]          r_lst_lvl [cpr_pkg::MAX_REPORT];
    logic [7:0]                 r_lst_stk [cpr_pkg::MAX_REPORT];
    logic [cpr_pkg::ADDR_W-1:0] n_lst_ch  [cpr_pkg::MAX_REPORT];
    logic signed [7:0]          n_lst_lvl [cpr_pkg::MAX_REPORT];
    logic [7:0]                 n_lst_stk [cpr_pkg::MAX_REPORT];
    logic [cpr_pkg::MAX_REPORT-1:0] ge;
    logic [cpr_pkg::MAX_REPORT-1:0] ge_prev;

    // Output register.
    logic                        r_out_valid;
    logic                        r_out_ent;
    logic [cpr_pkg::ADDR_W-1:0]  r_out_ch;
    logic [7:0]                  r_out_lvl;
    logic [7:0]                  r_out_stk;
    logic [cpr_pkg::FOUND_W-1:0] r_out_found;
    logic [15:0]                 r_out_pass;
    logic                        r_out_last;
    logic                        emit_last;

    assign n_act = (r_chan_cnt > cpr_pkg::CNT_W'(cpr_pkg::MAX_CHANNELS))
                 ? cpr_pkg::CNT_W'(cpr_pkg::MAX_CHANNELS) : r_chan_cnt;
    assign lim   = (r_rep_lim > cpr_pkg::FOUND_W'(cpr_pkg::MAX_REPORT))
                 ? cpr_pkg::FOUND_W'(cpr_pkg::MAX_REPORT) : r_rep_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_cnt <= cpr_pkg::RST_CHANNEL_COUNT;
            r_thr      <= cpr_pkg::RST_THRESHOLD;
            r_persist  <= cpr_pkg::RST_PERSIST;
            r_rep_lim  <= cpr_pkg::RST_REPORT_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                cpr_pkg::CFG_CHANNEL_COUNT: r_chan_cnt <= i_cfg_wdata[6:0];
                cpr_pkg::CFG_THRESHOLD:     r_thr      <= $signed(i_cfg_wdata);
                cpr_pkg::CFG_PERSIST:       r_persist  <= i_cfg_wdata;
                cpr_pkg::CFG_REPORT_LIMIT:  r_rep_lim  <= i_cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    // Memory read port serves the sample lookup and the scan.
    assign rd_addr = i_cmd.scan_step ? r_idx[cpr_pkg::ADDR_W-1:0] : i_in_ch;

    assign thr_ext = {r_thr[7], r_thr};
    assign old_stk = r_rd_init ? r_rd_word[15:8] : 8'd0;
    assign n_lvl   = (r_smp_rssi < -9'sd128) ? cpr_pkg::LEVEL_FLOOR : r_smp_rssi[7:0];

    always_comb begin
        if (r_smp_rssi > thr_ext) begin
            n_stk = (old_stk == cpr_pkg::STREAK_MAX) ? old_stk : old_stk + 8'd1;
        end else begin
            n_stk = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sample_wr) begin
            r_mem[r_smp_ch] <= {n_stk, n_lvl};
        end
        r_rd_word <= r_mem[rd_addr];
        r_rd_init <= r_valid[rd_addr];
        if (i_cmd.sample_start) begin
            r_smp_ch   <= i_in_ch;
            r_smp_rssi <= i_in_rssi;
        end
        r_eval_ch <= r_idx[cpr_pkg::ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_pass  <= '0;
        end else if (i_cmd.clear) begin
            r_valid <= '0;
            r_pass  <= '0;
        end else if (i_cmd.sample_wr) begin
            r_valid[r_smp_ch] <= 1'b1;
            if (({1'b0, r_smp_ch} == n_act - 7'd1) && (r_pass != cpr_pkg::PASS_MAX)) begin
                r_pass <= r_pass + 16'd1;
            end
        end
    end

    // Scan evaluation of the entry read in the previous cycle.
    assign ev_lvl = r_rd_init ? $signed(r_rd_word[7:0]) : cpr_pkg::LEVEL_RESET;
    assign ev_stk = r_rd_init ? r_rd_word[15:8] : 8'd0;
    assign hit    = r_eval_v && (r_found < lim) && (ev_stk >= r_persist);

    // A new entry arrives in ascending index order, so it goes after every
    // held entry whose level is not below its own.
    always_comb begin
        for (int k = 0; k < cpr_pkg::MAX_REPORT; k++) begin
            ge[k] = (cpr_pkg::FOUND_W'(k) < r_found) && (r_lst_lvl[k] >= ev_lvl);
        end
        ge_prev = {ge[cpr_pkg::MAX_REPORT-2:0], 1'b1};
        n_lst_ch[0]  = r_lst_ch[0];
        n_lst_lvl[0] = r_lst_lvl[0];
        n_lst_stk[0] = r_lst_stk[0];
        for (int k = 0; k < cpr_pkg::MAX_REPORT; k++) begin
            if (ge[k]) begin
                n_lst_ch[k]  = r_lst_ch[k];
                n_lst_lvl[k] = r_lst_lvl[k];
                n_lst_stk[k] = r_lst_stk[k];
            end else if (ge_prev[k]) begin
                n_lst_ch[k]  = r_eval_ch;
                n_lst_lvl[k] = ev_lvl;
                n_lst_stk[k] = ev_stk;
            end else begin
                n_lst_ch[k]  = r_lst_ch[(k + cpr_pkg::MAX_REPORT - 1) % cpr_pkg::MAX_REPORT];
                n_lst_lvl[k] = r_lst_lvl[(k + cpr_pkg::MAX_REPORT - 1) % cpr_pkg::MAX_REPORT];
                n_lst_stk[k] = r_lst_stk[(k + cpr_pkg::MAX_REPORT - 1) % cpr_pkg::MAX_REPORT];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit) begin
            for (int k = 0; k < cpr_pkg::MAX_REPORT; k++) begin
                r_lst_ch[k]  <= n_lst_ch[k];
                r_lst_lvl[k] <= n_lst_lvl[k];
                r_lst_stk[k] <= n_lst_stk[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_eval_v <= 1'b0;
            r_found  <= '0;
            r_emit   <= '0;
        end else if (i_cmd.scan_start) begin
            r_idx    <= '0;
            r_eval_v <= 1'b0;
            r_found  <= '0;
            r_emit   <= '0;
        end else begin
            r_eval_v <= i_cmd.scan_step && (r_idx < n_act);
            if (i_cmd.scan_step && (r_idx < n_act)) begin
                r_idx <= r_idx + 7'd1;
            end
            if (hit) begin
                r_found <= r_found + 4'd1;
            end
            if (i_cmd.emit_load && !emit_last) begin
                r_emit <= r_emit + 3'd1;
            end
        end
    end

    assign emit_last = (r_found == '0) || ({1'b0, r_emit} == r_found - 4'd1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_out_pass  <= r_pass;
            r_out_found <= r_found;
            r_out_last  <= emit_last;
            if (r_found == '0) begin
                r_out_ent <= 1'b0;
                r_out_ch  <= '0;
                r_out_lvl <= '0;
                r_out_stk <= '0;
            end else begin
                r_out_ent <= 1'b1;
                r_out_ch  <= r_lst_ch[r_emit];
                r_out_lvl <= r_lst_lvl[r_emit];
                r_out_stk <= r_lst_stk[r_emit];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.ch_in_range = ({1'b0, i_in_ch} < n_act);
    assign o_stat.scan_done   = (r_found >= lim) || (!r_eval_v && (r_idx >= n_act));
    assign o_stat.out_free    = !r_out_valid || i_m_tready;
    assign o_stat.emit_last   = emit_last;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_pass, r_out_found, r_out_stk, r_out_lvl, r_out_ch};
    assign o_m_tuser  = r_out_ent;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

@@ design/channel_persistence_ranker.sv @@
// ----------------------------------------------------------------------------
// channel_persistence_ranker
// Tracks per-channel levels and above-threshold streaks, and reports the
// persistent channels sorted by descending level.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  s_*       in         one item: sample, report request or clear all
//  m_*       out        one result item of a report
//  cfg_*     in         register write, no read-back
//
// A sample reads its table entry when the item is accepted and writes it back
// in the following cycle. A clear empties the table at once through per-entry
// valid flags. A report starts the scan, then walks the channels in use
// (channel_count capped at 64) through the table's single read port, stopping
// early once report_limit channels have been found, then emits one result
// item per cycle while the output is not stalled. The next item is accepted
// once the last result has been loaded into the output register, even if it
// is still waiting to be taken. Reset is synchronous and active low; no
// clearing pass follows.
//
// The table memory holds the level and the streak of each channel; an entry
// never written since reset or a clear reads as level -120 and streak zero.
// During a report the persistent channels found so far are kept in eight
// lanes in descending level order; each newly found channel is inserted behind
// every lane of equal or higher level, which keeps ties in index order.
// ----------------------------------------------------------------------------
`default_nettype none

module channel_persistence_ranker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [7:0]  i_cfg_wdata,
    // Input items.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // channel [5:0], rssi_dbm [14:6], zero [15]
    input  wire logic [1:0]  s_tuser,   // kind [1:0]
    // Result items.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // channel_res [5:0], level_dbm [13:6],
                                        // streak [21:14], found_count [25:22],
                                        // passes [41:26], zero [47:42]
    output logic [0:0]       m_tuser,   // entry_valid [0]
    output logic             m_tlast
);

    cpr_pkg::t_cmd  cmd;
    cpr_pkg::t_stat stat;

    cpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_kind     (s_tuser),
        .i_stat     (stat),
        .o_s_tready (s_tready),
        .o_cmd      (cmd)
    );

    cpr_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_ch     (s_tdata[5:0]),
        .i_in_rssi   ($signed(s_tdata[14:6])),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_m_tready  (m_tready),
        .o_m_tvalid  (m_tvalid),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
